// ===== design/mps_pkg.sv =====
// Package with the shared types and constants of the magnetometer poll sequencer.
`default_nettype none

package mps_pkg;

  // Field widths.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned WaitW  = 16;
  localparam int unsigned GainW  = 9;
  localparam int unsigned AxisW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [WaitW-1:0] WAIT_RESET = 16'd8000;
  localparam logic [GainW-1:0] GAIN_RESET = 9'd256;

  // Status bit masks.
  localparam logic [ByteW-1:0] ST1_READY    = 8'h01;
  localparam logic [ByteW-1:0] ST1_OVERRUN  = 8'h02;
  localparam logic [ByteW-1:0] ST2_OVERFLOW = 8'h08;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WAIT   = 2'd0,
    CFG_GAIN_X = 2'd1,
    CFG_GAIN_Y = 2'd2,
    CFG_GAIN_Z = 2'd3
  } cfg_idx_t;

  // Sequencer phases; the unused code acts as check status.
  typedef enum logic [1:0] {
    PH_CHECK = 2'd0,
    PH_WSTAT = 2'd1,
    PH_WDATA = 2'd2
  } phase_t;

  // Read request codes.
  typedef enum logic [ReqW-1:0] {
    REQ_NONE   = 2'd0,
    REQ_STATUS = 2'd1,
    REQ_DATA   = 2'd2
  } req_t;

  // What a poll does to the axis cache.
  typedef enum logic [1:0] {
    UPD_KEEP  = 2'd0,
    UPD_STORE = 2'd1,
    UPD_FAIL  = 2'd2
  } upd_t;

  // Decision of one poll, carried from the controller to the merge stage.
  typedef struct packed {
    logic valid;
    req_t req;
    upd_t upd;
  } step_t;

endpackage

`default_nettype wire

// ===== design/mps_if.sv =====
// Valid/ready channel interfaces for poll beats and result beats.
`default_nettype none

interface mps_in_if;
  import mps_pkg::*;
  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  now_us;
  logic [ByteW-1:0]  status_one;
  logic [AxisW-1:0]  raw_x;
  logic [AxisW-1:0]  raw_y;
  logic [AxisW-1:0]  raw_z;
  logic [ByteW-1:0]  status_two;

  modport source (output valid, now_us, status_one, raw_x, raw_y, raw_z, status_two,
                  input ready);
  modport sink (input valid, now_us, status_one, raw_x, raw_y, raw_z, status_two,
                output ready);
endinterface

interface mps_out_if;
  import mps_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ReqW-1:0]         read_request;
  logic                    read_ok;
  logic signed [AxisW-1:0] mag_x;
  logic signed [AxisW-1:0] mag_y;
  logic signed [AxisW-1:0] mag_z;

  modport source (output valid, read_request, read_ok, mag_x, mag_y, mag_z, input ready);
  modport sink (input valid, read_request, read_ok, mag_x, mag_y, mag_z, output ready);
endinterface

`default_nettype wire

// ===== design/magnetometer_poll_sequencer_top.sv =====
// Top level of the magnetometer poll sequencer.
`default_nettype none

// Each poll beat yields exactly one result beat. A poll is accepted every clock cycle
// when the result side keeps up, and its result passes through these registers: the phase
// register and the start time update at acceptance, the three axis lanes register
// their scaled values alongside, and the merge stage folds them into the cache and
// the result register. The sustained rate of one poll per cycle is set by the phase
// and start-time loop, which closes in the acceptance cycle. Configuration writes
// take effect at the next edge and are meant to be made while no poll is in flight.
module magnetometer_poll_sequencer_top
  import mps_pkg::*;
#(
  parameter logic [WaitW-1:0] WaitReset = WAIT_RESET,
  parameter logic [GainW-1:0] GainReset = GAIN_RESET
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [CfgDataW-1:0]   cfg_data,
  mps_in_if.sink                     in_ch,
  mps_out_if.source                  out_ch
);

  logic [WaitW-1:0]        wait_us;
  logic [GainW-1:0]        gain_x;
  logic [GainW-1:0]        gain_y;
  logic [GainW-1:0]        gain_z;
  logic                    accept;
  logic                    out_adv;
  step_t                   step;
  logic signed [AxisW-1:0] lane_x;
  logic signed [AxisW-1:0] lane_y;
  logic signed [AxisW-1:0] lane_z;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_us <= WaitReset;
      gain_x  <= GainReset;
      gain_y  <= GainReset;
      gain_z  <= GainReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WAIT:   wait_us <= cfg_data[WaitW-1:0];
        CFG_GAIN_X: gain_x  <= cfg_data[GainW-1:0];
        CFG_GAIN_Y: gain_y  <= cfg_data[GainW-1:0];
        CFG_GAIN_Z: gain_z  <= cfg_data[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Phase controller.
  mps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .now_us     (in_ch.now_us),
    .status_one (in_ch.status_one),
    .status_two (in_ch.status_two),
    .wait_us    (wait_us),
    .out_adv    (out_adv),
    .accept     (accept),
    .step       (step)
  );

  // Axis lanes; X and Z are negated.
  mps_lane #(.Negate(1'b1)) u_lane_x (
    .clk (clk), .en (accept), .raw (in_ch.raw_x), .gain (gain_x), .scaled (lane_x)
  );
  mps_lane #(.Negate(1'b0)) u_lane_y (
    .clk (clk), .en (accept), .raw (in_ch.raw_y), .gain (gain_y), .scaled (lane_y)
  );
  mps_lane #(.Negate(1'b1)) u_lane_z (
    .clk (clk), .en (accept), .raw (in_ch.raw_z), .gain (gain_z), .scaled (lane_z)
  );

  // Merge stage and result register.
  mps_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .lane_x  (lane_x),
    .lane_y  (lane_y),
    .lane_z  (lane_z),
    .out_adv (out_adv),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== design/mps_lane.sv =====
// One axis lane: multiply by gain, divide by 256 toward zero, saturate, optional negate.
`default_nettype none

module mps_lane
  import mps_pkg::*;
#(
  parameter bit Negate = 1'b0
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [AxisW-1:0]        raw,
  input  wire logic [GainW-1:0]        gain,
  output logic signed [AxisW-1:0]      scaled
);

  localparam int unsigned ProdW = AxisW + GainW + 1;
  localparam int unsigned QuotW = ProdW - 8;
  localparam logic signed [QuotW-1:0] QMax = QuotW'(32767);
  localparam logic signed [QuotW-1:0] QMin = -QuotW'(32768);

  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  prod_adj;
  logic signed [QuotW-1:0]  quot;
  logic signed [AxisW-1:0]  sat;
  logic signed [AxisW-1:0]  result;

  // Signed product; bias negative values so the shift truncates toward zero.
  always_comb begin
    prod     = ProdW'($signed(raw)) * $signed({1'b0, gain});
    prod_adj = prod + (prod[ProdW-1] ? ProdW'(255) : ProdW'(0));
    quot     = prod_adj[ProdW-1:8];
  end

  // Saturate to the 16-bit range, then negate with the most negative value clamped.
  always_comb begin
    if (quot > QMax) begin
      sat = 16'sh7fff;
    end else if (quot < QMin) begin
      sat = 16'sh8000;
    end else begin
      sat = quot[AxisW-1:0];
    end
    if (!Negate) begin
      result = sat;
    end else if (sat == 16'sh8000) begin
      result = 16'sh7fff;
    end else begin
      result = -sat;
    end
  end

  // The lane result is registered with each accepted poll.
  always_ff @(posedge clk) begin
    if (en) begin
      scaled <= result;
    end
  end

endmodule

`default_nettype wire

// ===== design/mps_ctrl.sv =====
// Phase controller: read sequencing, wait timing and pipeline handshake.
`default_nettype none

module mps_ctrl
  import mps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [TimeW-1:0]  now_us,
  input  wire logic [ByteW-1:0]  status_one,
  input  wire logic [ByteW-1:0]  status_two,
  input  wire logic [WaitW-1:0]  wait_us,
  input  wire logic              out_adv,
  output logic                   accept,
  output step_t                  step
);

  phase_t            phase;
  phase_t            phase_next;
  logic [TimeW-1:0]  started;
  logic [TimeW-1:0]  started_next;
  step_t             step_next;
  logic [TimeW-1:0]  elapsed;
  logic              wait_done;

  // Elapsed time is signed; a negative value still counts as waiting.
  always_comb begin
    elapsed   = now_us - started;
    wait_done = !elapsed[TimeW-1] && (elapsed >= {{(TimeW-WaitW){1'b0}}, wait_us});
  end

  // Handshake outputs: a stage-one beat may move on while the next one enters.
  always_comb begin
    in_ready = !step.valid || out_adv;
    accept   = in_valid && in_ready;
  end

  // Next phase, request and cache action for an accepted poll.
  always_comb begin
    phase_next   = phase;
    started_next = started;
    step_next    = step;
    if (accept) begin
      step_next.valid = 1'b1;
      step_next.req   = REQ_NONE;
      step_next.upd   = UPD_KEEP;
      unique case (phase)
        PH_WSTAT: begin
          if (wait_done) begin
            if ((status_one & (ST1_READY | ST1_OVERRUN)) == '0) begin
              phase_next = PH_CHECK;
            end else begin
              step_next.req = REQ_DATA;
              started_next  = now_us;
              phase_next    = PH_WDATA;
            end
          end
        end
        PH_WDATA: begin
          if (wait_done) begin
            step_next.upd = ((status_two & ST2_OVERFLOW) != '0) ? UPD_FAIL : UPD_STORE;
            phase_next    = PH_CHECK;
          end
        end
        default: begin
          step_next.req = REQ_STATUS;
          started_next  = now_us;
          phase_next    = PH_WSTAT;
        end
      endcase
    end else if (out_adv) begin
      step_next.valid = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CHECK;
      started    <= '0;
      step.valid <= 1'b0;
      step.req   <= REQ_NONE;
      step.upd   <= UPD_KEEP;
    end else begin
      phase   <= phase_next;
      started <= started_next;
      step    <= step_next;
    end
  end

  // A poll in check status always issues a status read.
  a_check_issues_status: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_CHECK |=> step.req == REQ_STATUS && phase == PH_WSTAT)
    else $error("check status poll did not issue a status read");

  // The start time follows the poll that issued a read.
  a_start_time: assert property (@(posedge clk) disable iff (rst)
    accept && step_next.req != REQ_NONE |=> started == $past(now_us))
    else $error("read start time not recorded");

  // A stage-one beat that cannot move on is held.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    step.valid && !out_adv |=> step.valid && $stable(step))
    else $error("stage-one beat lost under stall");

endmodule

`default_nettype wire

// ===== design/mps_merge.sv =====
// Merge stage: combines the lane results into the axis cache and the result register.
`default_nettype none

module mps_merge
  import mps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire step_t                   step,
  input  wire logic signed [AxisW-1:0] lane_x,
  input  wire logic signed [AxisW-1:0] lane_y,
  input  wire logic signed [AxisW-1:0] lane_z,
  output logic                         out_adv,
  mps_out_if.source                    out_ch
);

  logic                    out_valid;
  req_t                    req;
  logic                    last_ok;
  logic signed [AxisW-1:0] cached_x;
  logic signed [AxisW-1:0] cached_y;
  logic signed [AxisW-1:0] cached_z;
  logic                    move;

  // The result register is free when empty or being taken.
  always_comb begin
    out_adv = !out_valid || out_ch.ready;
    move    = step.valid && out_adv;
  end

  // Cache and result register update.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      req       <= REQ_NONE;
      last_ok   <= 1'b0;
      cached_x  <= '0;
      cached_y  <= '0;
      cached_z  <= '0;
    end else if (move) begin
      out_valid <= 1'b1;
      req       <= step.req;
      unique case (step.upd)
        UPD_STORE: begin
          cached_x <= lane_x;
          cached_y <= lane_y;
          cached_z <= lane_z;
          last_ok  <= 1'b1;
        end
        UPD_FAIL: begin
          last_ok <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result beat.
  assign out_ch.valid        = out_valid;
  assign out_ch.read_request = req;
  assign out_ch.read_ok      = last_ok;
  assign out_ch.mag_x        = cached_x;
  assign out_ch.mag_y        = cached_y;
  assign out_ch.mag_z        = cached_z;

endmodule

`default_nettype wire

// ===== tb/mps_tb_pkg.sv =====
// Beat types and the result scoreboard for the magnetometer poll sequencer testbench.
`timescale 1ns / 1ps

package mps_tb_pkg;
  import mps_pkg::*;

  // One poll beat as offered on the input channel.
  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic [ByteW-1:0] status_one;
    logic [AxisW-1:0] raw_x;
    logic [AxisW-1:0] raw_y;
    logic [AxisW-1:0] raw_z;
    logic [ByteW-1:0] status_two;
  } poll_t;

  // One result beat as predicted for the output channel.
  typedef struct packed {
    req_t                    read_request;
    logic                    read_ok;
    logic signed [AxisW-1:0] mag_x;
    logic signed [AxisW-1:0] mag_y;
    logic signed [AxisW-1:0] mag_z;
  } result_t;

  // Tracks the sequencer state, predicts each poll's result and checks result beats.
  class poll_scoreboard;
    logic [WaitW-1:0]        wait_cfg;
    logic [GainW-1:0]        gain_cfg_x;
    logic [GainW-1:0]        gain_cfg_y;
    logic [GainW-1:0]        gain_cfg_z;
    phase_t                  phase;
    logic [TimeW-1:0]        started_at;
    logic                    last_ok;
    logic signed [AxisW-1:0] cache_x;
    logic signed [AxisW-1:0] cache_y;
    logic signed [AxisW-1:0] cache_z;
    result_t                 expected_results[$];
    int                      errors;

    function new();
      wait_cfg   = WAIT_RESET;
      gain_cfg_x = GAIN_RESET;
      gain_cfg_y = GAIN_RESET;
      gain_cfg_z = GAIN_RESET;
      phase      = PH_CHECK;
      started_at = '0;
      last_ok    = 1'b0;
      cache_x    = '0;
      cache_y    = '0;
      cache_z    = '0;
      errors     = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_WAIT:   wait_cfg = data[WaitW-1:0];
        CFG_GAIN_X: gain_cfg_x = data[GainW-1:0];
        CFG_GAIN_Y: gain_cfg_y = data[GainW-1:0];
        CFG_GAIN_Z: gain_cfg_z = data[GainW-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Signed 32-bit elapsed time since the read was issued; negative counts as waiting.
    function bit wait_done(logic [TimeW-1:0] now);
      logic signed [TimeW-1:0] elapsed;
      elapsed = now - started_at;
      return longint'(elapsed) >= longint'(wait_cfg);
    endfunction

    // Raw sample times gain over 256, truncated toward zero, saturated to 16 bits.
    function logic signed [AxisW-1:0] scale_axis(logic [AxisW-1:0] raw,
                                                 logic [GainW-1:0] gain);
      int prod;
      int q;
      prod = int'(signed'(raw)) * int'(gain);
      q = prod / 256;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[AxisW-1:0];
    endfunction

    function logic signed [AxisW-1:0] negate_sat(logic signed [AxisW-1:0] v);
      if (v == 16'sh8000) return 16'sh7FFF;
      return -v;
    endfunction

    // Advances the phase machine by one accepted poll and queues its result.
    function void note_poll(poll_t p);
      result_t r;
      r.read_request = REQ_NONE;
      case (phase)
        PH_WSTAT: begin
          if (wait_done(p.now_us)) begin
            if ((p.status_one & (ST1_READY | ST1_OVERRUN)) == '0) begin
              phase = PH_CHECK;
            end else begin
              r.read_request = REQ_DATA;
              started_at = p.now_us;
              phase = PH_WDATA;
            end
          end
        end
        PH_WDATA: begin
          if (wait_done(p.now_us)) begin
            if ((p.status_two & ST2_OVERFLOW) != '0) begin
              last_ok = 1'b0;
            end else begin
              cache_x = negate_sat(scale_axis(p.raw_x, gain_cfg_x));
              cache_y = scale_axis(p.raw_y, gain_cfg_y);
              cache_z = negate_sat(scale_axis(p.raw_z, gain_cfg_z));
              last_ok = 1'b1;
            end
            phase = PH_CHECK;
          end
        end
        default: begin
          // Check status, and the unused phase code as well.
          r.read_request = REQ_STATUS;
          started_at = p.now_us;
          phase = PH_WSTAT;
        end
      endcase
      r.read_ok = last_ok;
      r.mag_x = cache_x;
      r.mag_y = cache_y;
      r.mag_z = cache_z;
      expected_results.push_back(r);
    endfunction

    // Compares one result beat with the oldest prediction.
    function void check_result(logic [ReqW-1:0] got_req, logic got_ok,
                               logic signed [AxisW-1:0] got_x,
                               logic signed [AxisW-1:0] got_y,
                               logic signed [AxisW-1:0] got_z);
      result_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with no poll pending: read_request %0d", got_req);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (got_req !== e.read_request) begin
        $error("read_request: expected %0d, got %0d", e.read_request, got_req);
        errors++;
      end
      if (got_ok !== e.read_ok) begin
        $error("read_ok: expected %0d, got %0d", e.read_ok, got_ok);
        errors++;
      end
      if (got_x !== e.mag_x) begin
        $error("mag_x: expected %0d, got %0d", e.mag_x, got_x);
        errors++;
      end
      if (got_y !== e.mag_y) begin
        $error("mag_y: expected %0d, got %0d", e.mag_y, got_y);
        errors++;
      end
      if (got_z !== e.mag_z) begin
        $error("mag_z: expected %0d, got %0d", e.mag_z, got_z);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench of the magnetometer poll sequencer: stimulus, result sink and checks.
`timescale 1ns / 1ps

module tb;
  import mps_pkg::*;
  import mps_tb_pkg::*;

  localparam int Phases = 12;
  localparam int PollsPerPhase = 152;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  mps_in_if in_ch();
  mps_out_if out_ch();

  poll_scoreboard sb;
  logic [TimeW-1:0] clock_us;
  logic [WaitW-1:0] wait_setting;
  bit idle_on;

  magnetometer_poll_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic poll_t poll_beat(logic [TimeW-1:0] t, logic [ByteW-1:0] s1,
                                      logic [AxisW-1:0] rx, logic [AxisW-1:0] ry,
                                      logic [AxisW-1:0] rz, logic [ByteW-1:0] s2);
    poll_t p;
    p.now_us = t;
    p.status_one = s1;
    p.raw_x = rx;
    p.raw_y = ry;
    p.raw_z = rz;
    p.status_two = s2;
    return p;
  endfunction

  // Axis samples lean toward the saturating extremes.
  function automatic logic [AxisW-1:0] pick_raw();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return AxisW'($urandom());
    endcase
  endfunction

  // Builds a random poll whose time often lands near the end of the current wait.
  task automatic gen_poll(output poll_t p);
    int r;
    int w;
    w = int'(wait_setting);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      clock_us = $urandom();
    end else if (r < 7) begin
      clock_us = sb.started_at - $urandom_range(1, 5000);
    end else if (r < 32) begin
      clock_us = sb.started_at + w + $urandom_range(0, 2) - 1;
    end else begin
      clock_us = clock_us + $urandom_range(0, w / 2 + 2);
    end
    p.now_us = clock_us;
    if ($urandom_range(0, 99) < 70) begin
      p.status_one = ByteW'($urandom()) | ByteW'($urandom_range(1, 3));
    end else begin
      p.status_one = ByteW'($urandom()) & ~(ST1_READY | ST1_OVERRUN);
    end
    p.raw_x = pick_raw();
    p.raw_y = pick_raw();
    p.raw_z = pick_raw();
    if ($urandom_range(0, 99) < 20) begin
      p.status_two = ByteW'($urandom()) | ST2_OVERFLOW;
    end else begin
      p.status_two = ByteW'($urandom()) & ~ST2_OVERFLOW;
    end
  endtask

  // Offers one poll beat, after a random gap while gaps are on, and records it once accepted.
  task automatic send_poll(input poll_t p);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.now_us     <= p.now_us;
    in_ch.status_one <= p.status_one;
    in_ch.raw_x      <= p.raw_x;
    in_ch.raw_y      <= p.raw_y;
    in_ch.raw_z      <= p.raw_z;
    in_ch.status_two <= p.status_two;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_poll(p);
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles.
  task automatic apply_settings(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] gx,
                                input logic [CfgDataW-1:0] gy, input logic [CfgDataW-1:0] gz);
    logic [CfgDataW-1:0] vals[4];
    vals[0] = w;
    vals[1] = gx;
    vals[2] = gy;
    vals[3] = gz;
    for (int k = 0; k < 4; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_idx_t'(k);
      cfg_data  <= vals[k];
      @(posedge clk);
      sb.set_register(cfg_idx_t'(k), vals[k]);
    end
    cfg_wr_en <= 1'b0;
    wait_setting = w;
  endtask

  function automatic logic [CfgDataW-1:0] pick_gain();
    if ($urandom_range(0, 1) != 0) return CfgDataW'($urandom_range(128, 383));
    return CfgDataW'($urandom());
  endfunction

  // Result sink: random stalls, and two long hold-offs that back the block up.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 240 || taken == 1000) begin
        stall = 150;
      end else begin
        stall = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.read_request, out_ch.read_ok, out_ch.mag_x, out_ch.mag_y,
                      out_ch.mag_z);
    end
  end

  initial begin : stimulus
    poll_t p;
    poll_t directed_polls[$];
    logic [CfgDataW-1:0] w;

    sb = new();
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= CFG_WAIT;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.now_us     <= '0;
    in_ch.status_one <= '0;
    in_ch.raw_x      <= '0;
    in_ch.raw_y      <= '0;
    in_ch.raw_z      <= '0;
    in_ch.status_two <= '0;
    clock_us = '0;
    wait_setting = WAIT_RESET;
    idle_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed polls at the reset settings: wait 8000, unity gain.
    directed_polls.push_back(poll_beat(32'd0, 8'h00, 16'h1234, 16'h5678, 16'h9ABC, 8'hFF));
    directed_polls.push_back(poll_beat(32'd100, 8'hFF, 16'h0, 16'h0, 16'h0, 8'h00));
    // Status not ready once the wait has run out.
    directed_polls.push_back(poll_beat(32'd8000, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));
    directed_polls.push_back(poll_beat(32'd8001, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
    directed_polls.push_back(poll_beat(32'd16001, ST1_READY, 16'h0, 16'h0, 16'h0, 8'hFF));
    // Time running backward counts as still waiting.
    directed_polls.push_back(poll_beat(32'd15996, 8'h00, 16'h1, 16'h1, 16'h1, ST2_OVERFLOW));
    // Most negative sample negates to the positive limit.
    directed_polls.push_back(poll_beat(32'd24001, 8'h00, 16'h8000, 16'h7FFF, 16'hFFFF, 8'h00));
    directed_polls.push_back(poll_beat(32'd24002, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
    directed_polls.push_back(poll_beat(32'd32002, ST1_OVERRUN, 16'h0, 16'h0, 16'h0, 8'h00));
    // Data overflow keeps the cache and clears the good flag.
    directed_polls.push_back(poll_beat(32'd40002, 8'h00, 16'h4321, 16'h1111, 16'h2222, 8'hFF));
    // A wait that straddles the wrap of the microsecond counter.
    directed_polls.push_back(poll_beat(32'hFFFF_FFF0, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
    directed_polls.push_back(poll_beat(32'd7984, 8'h03, 16'h0, 16'h0, 16'h0, 8'h00));
    directed_polls.push_back(poll_beat(32'd15983, 8'hFF, 16'h0, 16'h0, 16'h0, 8'h00));
    directed_polls.push_back(poll_beat(32'd15984, 8'h00, 16'h7FFF, 16'h8000, 16'h0001, 8'hF7));
    directed_polls.push_back(poll_beat(32'd15985, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
    // Elapsed time past half the counter range reads as negative.
    directed_polls.push_back(poll_beat(32'h8000_3E71, 8'hFF, 16'h0, 16'h0, 16'h0, 8'h00));
    directed_polls.push_back(poll_beat(32'd23985, 8'hFC, 16'h0, 16'h0, 16'h0, 8'h00));
    directed_polls.push_back(poll_beat(32'd23986, 8'h00, 16'h0, 16'h0, 16'h0, 8'h00));
    foreach (directed_polls[k]) send_poll(directed_polls[k]);
    clock_us = 32'd23986;

    // Random phases, each under its own register settings.
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: apply_settings(16'd0, 16'd128, 16'd128, 16'd128);
          2: apply_settings(16'd65535, 16'd383, 16'd383, 16'd383);
          3: apply_settings(16'd3, 16'hFFFF, 16'hFE00, 16'd0);
          default: begin
            if ($urandom_range(0, 3) == 0) w = CfgDataW'($urandom());
            else w = CfgDataW'($urandom_range(0, 40));
            apply_settings(w, pick_gain(), pick_gain(), pick_gain());
          end
        endcase
      end
      if ($urandom_range(0, 1) != 0) begin
        clock_us = 32'hFFFF_FFFF - $urandom_range(0, 4 * int'(wait_setting) + 8);
      end
      for (int i = 0; i < PollsPerPhase; i++) begin
        if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        gen_poll(p);
        send_poll(p);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
design/mps_pkg.sv
design/mps_if.sv
design/mps_lane.sv
design/mps_ctrl.sv
design/mps_merge.sv
design/magnetometer_poll_sequencer_top.sv
tb/mps_tb_pkg.sv
tb/tb.sv
